@@ src/fsd_pkg.sv @@
// fsd_pkg: shared constants, types and the clamped error-add function for the
// binary error-diffusion dither. No dependencies.
`default_nettype none

package fsd_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int PixW     = 8;
  localparam int ErrW     = 9;
  localparam int CfgWidthW = 11;
  localparam int ThrW     = 8;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic [CfgWidthW-1:0] WidthReset = 11'd640;
  localparam logic [ThrW-1:0]      ThrReset   = 8'd128;
  localparam logic [PixW-1:0]      PixMax     = 8'd255;

  // diffusion weights, in sixteenths
  localparam logic [2:0] WeightAboveLeft  = 3'd1;
  localparam logic [2:0] WeightAbove      = 3'd5;
  localparam logic [2:0] WeightAboveRight = 3'd3;
  localparam logic [2:0] WeightLeft       = 3'd7;

  // register index, taken from paddr[2]
  localparam logic RegImageWidth = 1'b0;
  localparam logic RegThreshold  = 1'b1;

  typedef struct packed {
    logic [CfgWidthW-1:0] image_width;
    logic [ThrW-1:0]      threshold;
  } cfg_t;

  // v + trunc(err * weight / 16), clamped to 0..255
  function automatic logic [PixW-1:0] add_clamp(input logic [PixW-1:0] v,
                                                input logic signed [ErrW-1:0] err,
                                                input logic [2:0] weight);
    logic signed [12:0] prod;
    logic signed [12:0] q;
    logic signed [12:0] sum;
    prod = err * $signed({1'b0, weight});
    if (prod < 0) begin
      q = (prod + 13'sd15) >>> 4;
    end else begin
      q = prod >>> 4;
    end
    sum = $signed({5'b0, v}) + q;
    if (sum < 0) begin
      add_clamp = '0;
    end else if (sum > $signed({5'b0, PixMax})) begin
      add_clamp = PixMax;
    end else begin
      add_clamp = sum[PixW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ src/fsd_pix_in_if.sv @@
// fsd_pix_in_if: valid/ready channel carrying one grey input pixel word.
// Depends on fsd_pkg.
`default_nettype none

interface fsd_pix_in_if;
  logic                      valid;
  logic                      ready;
  logic [fsd_pkg::PixW-1:0]  pixel;
  logic                      frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

`default_nettype wire

@@ src/fsd_pix_out_if.sv @@
// fsd_pix_out_if: valid/ready channel carrying one binary output pixel word.
// Depends on fsd_pkg.
`default_nettype none

interface fsd_pix_out_if;
  logic                      valid;
  logic                      ready;
  logic [fsd_pkg::PixW-1:0]  dithered;
  logic                      row_end;

  modport source (output valid, output dithered, output row_end, input ready);
  modport sink   (input valid, input dithered, input row_end, output ready);
endinterface

`default_nettype wire

@@ src/fsd_ram.sv @@
// fsd_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
`default_nettype none

module fsd_ram #(
  parameter int Width = 9,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr0_i,
  input  wire logic [$clog2(Depth)-1:0] raddr1_i,
  output logic      [Width-1:0]         rdata0_o,
  output logic      [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

@@ src/fsd_cfg.sv @@
// fsd_cfg: APB register file holding image width and threshold.
// Depends on fsd_pkg.
`default_nettype none

module fsd_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fsd_pkg::AddrW-1:0]   paddr,
  input  wire logic [fsd_pkg::DataW-1:0]   pwdata,
  output logic      [fsd_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output fsd_pkg::cfg_t                    cfg_o
);
  import fsd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        RegImageWidth: cfg_d.image_width = pwdata[CfgWidthW-1:0];
        RegThreshold:  cfg_d.threshold   = pwdata[ThrW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= WidthReset;
      cfg_q.threshold   <= ThrReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegImageWidth: prdata = {{(DataW-CfgWidthW){1'b0}}, cfg_q.image_width};
      RegThreshold:  prdata = {{(DataW-ThrW){1'b0}}, cfg_q.threshold};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ src/floyd_steinberg_binary_dither.sv @@
// floyd_steinberg_binary_dither: top level of the binary error-diffusion dither.
// Depends on fsd_pkg, fsd_pix_in_if, fsd_pix_out_if, fsd_ram and fsd_cfg.
//
// usage
//   pix_i carries grey pixel words in raster order; frame_start marks the first
//   pixel of a frame. dith_o carries one binary word (0 or 255) per input word,
//   with row_end set on the last pixel of each row.
//   the APB port holds image_width (addr 0) and threshold (addr 4); write them
//   only while the block is idle.
// latency and throughput
//   a word accepted at a clock edge shows on dith_o right after it. one word
//   per cycle is sustained while dith_o is ready and no register is written;
//   the per-pixel path is four clamped adds between state and output registers.
//   the previous row's errors live in a 1024 x 9 RAM with two registered read
//   ports, prefetched for the next word, with a forward path for the entry just
//   written. in the cycle right after a register write pix_i is held not ready,
//   so the prefetch is redone with the new width before the next word.
// reset
//   counters go to column 0 of a first row, carried errors to zero, width to
//   640 and threshold to 128. the error RAM is not cleared: the first row of a
//   frame never reads it.
// stall
//   a held result waits in the output register; pix_i stays ready while the
//   result is taken in the same cycle, and drops while dith_o is stalled.
`default_nettype none

module floyd_steinberg_binary_dither (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  fsd_pix_in_if.sink                       pix_i,
  fsd_pix_out_if.source                    dith_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fsd_pkg::AddrW-1:0]   paddr,
  input  wire logic [fsd_pkg::DataW-1:0]   pwdata,
  output logic      [fsd_pkg::DataW-1:0]   prdata,
  output logic                             pready
);
  import fsd_pkg::*;

  cfg_t cfg;

  // row / column tracking
  logic [ColW-1:0] col_cnt_q, col_cnt_d;
  logic            first_row_q, first_row_d;

  // carried errors
  logic signed [ErrW-1:0] left_err_q, left_err_d;
  logic signed [ErrW-1:0] above_left_q, above_left_d;

  // write forwarding for the entry written at the last edge
  logic                   fwd_hit0_q, fwd_hit0_d;
  logic                   fwd_hit1_q, fwd_hit1_d;
  logic signed [ErrW-1:0] fwd_data_q;

  // register written at the last edge, prefetch still on the old width
  logic            cfg_wr_q, cfg_wr_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic [PixW-1:0] out_pix_q;
  logic            out_row_end_q;

  logic            accept;
  logic [CfgWidthW-1:0] w_eff;
  logic [ColW-1:0] last_col;
  logic [ColW-1:0] col_base;
  logic [ColW-1:0] col;
  logic            last;
  logic            first_row;
  logic [ColW-1:0] raddr0, raddr1;
  logic [ErrW-1:0] rdata0, rdata1;
  logic signed [ErrW-1:0] above, above_right;
  logic [PixW-1:0] v_al, v_a, v_ar, v_l;
  logic [PixW-1:0] result;
  logic signed [ErrW-1:0] err;

  fsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign cfg_wr_d = psel && penable && pwrite && pready;

  // output register frees when empty or being taken; one idle cycle after a
  // register write lets the prefetch see the new width
  assign pix_i.ready = (!out_valid_q || dith_o.ready) && !cfg_wr_q;
  assign accept      = pix_i.valid && pix_i.ready;

  // width out of range is pulled into 1..MaxWidth
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = CfgWidthW'(1);
    end else if (cfg.image_width > CfgWidthW'(MaxWidth)) begin
      w_eff = CfgWidthW'(MaxWidth);
    end else begin
      w_eff = cfg.image_width;
    end
  end
  assign last_col = ColW'(w_eff - CfgWidthW'(1));

  // current pixel position; frame start forces column 0 of a first row
  assign first_row = pix_i.frame_start ? 1'b1 : first_row_q;
  assign col_base  = pix_i.frame_start ? '0 : col_cnt_q;
  assign col       = (col_base > last_col) ? last_col : col_base;
  assign last      = (col == last_col);

  // previous-row errors at col and col+1, forwarded if just written
  assign above       = fwd_hit0_q ? fwd_data_q : $signed(rdata0);
  assign above_right = fwd_hit1_q ? fwd_data_q : $signed(rdata1);

  // diffusion chain, clamped after each add
  always_comb begin
    v_al = pix_i.pixel;
    if (!first_row && (col != '0)) begin
      v_al = add_clamp(pix_i.pixel, above_left_q, WeightAboveLeft);
    end
    v_a = v_al;
    if (!first_row) begin
      v_a = add_clamp(v_al, above, WeightAbove);
    end
    v_ar = v_a;
    if (!first_row && !last) begin
      v_ar = add_clamp(v_a, above_right, WeightAboveRight);
    end
    v_l = v_ar;
    if (col != '0) begin
      v_l = add_clamp(v_ar, left_err_q, WeightLeft);
    end
  end

  assign result = (v_l > cfg.threshold) ? PixMax : '0;
  assign err    = $signed({1'b0, v_l} - {1'b0, result});

  // next state
  always_comb begin
    col_cnt_d    = col_cnt_q;
    first_row_d  = first_row_q;
    left_err_d   = left_err_q;
    above_left_d = above_left_q;
    if (accept) begin
      col_cnt_d    = last ? '0 : col + ColW'(1);
      first_row_d  = last ? 1'b0 : first_row;
      left_err_d   = err;
      above_left_d = first_row ? '0 : above;
    end
  end

  // prefetch the next pixel's above and above-right entries
  assign raddr0 = (col_cnt_d > last_col) ? last_col : col_cnt_d;
  assign raddr1 = raddr0 + ColW'(1);

  assign fwd_hit0_d = accept && (raddr0 == col);
  assign fwd_hit1_d = accept && (raddr1 == col);

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (dith_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  fsd_ram #(
    .Width (ErrW),
    .Depth (MaxWidth)
  ) u_err_line (
    .clk_i    (clk_i),
    .we_i     (accept),
    .waddr_i  (col),
    .wdata_i  (err),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q    <= '0;
      first_row_q  <= 1'b1;
      left_err_q   <= '0;
      above_left_q <= '0;
      fwd_hit0_q   <= 1'b0;
      fwd_hit1_q   <= 1'b0;
      cfg_wr_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      col_cnt_q    <= col_cnt_d;
      first_row_q  <= first_row_d;
      left_err_q   <= left_err_d;
      above_left_q <= above_left_d;
      fwd_hit0_q   <= fwd_hit0_d;
      fwd_hit1_q   <= fwd_hit1_d;
      cfg_wr_q     <= cfg_wr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fwd_data_q <= err;
    if (accept) begin
      out_pix_q     <= result;
      out_row_end_q <= last;
    end
  end

  assign dith_o.valid    = out_valid_q;
  assign dith_o.dithered = out_pix_q;
  assign dith_o.row_end  = out_row_end_q;

endmodule

`default_nettype wire

@@ tb/sv/floyd_steinberg_binary_dither_test.sv @@
// floyd_steinberg_binary_dither_test: self-checking bench for the binary error-diffusion
// dither; a scoreboard class predicts every output word, plain tasks drive the inputs.
// Depends on fsd_pkg, fsd_pix_in_if, fsd_pix_out_if and floyd_steinberg_binary_dither.
`default_nettype none

module floyd_steinberg_binary_dither_test;
  import fsd_pkg::*;

  // byte addresses of the two registers, 4 bytes apart
  localparam logic [AddrW-1:0] WidthAddr = {RegImageWidth, 2'b00};
  localparam logic [AddrW-1:0] ThrAddr   = {RegThreshold, 2'b00};

  // enough words at the widest setting to get into the second row
  localparam int WidePixels     = MaxWidth + 16;
  // words at the exact maximum width and one past it
  localparam int EdgePixels     = 16;
  localparam int DirectedPixels = 22;
  localparam int RandomPixels   = 1250 - DirectedPixels - WidePixels - 2 * EdgePixels;

  typedef struct packed {
    logic [PixW-1:0] dithered;
    logic            row_end;
  } dith_word_t;

  // tracks the dither state word by word and holds the outputs still owed
  class dither_checker;
    logic [CfgWidthW-1:0]   width_reg;
    logic [ThrW-1:0]        thr_reg;
    logic signed [ErrW-1:0] row_errors [MaxWidth];
    bit                     row_written [MaxWidth];
    logic signed [ErrW-1:0] above_left_err;
    logic signed [ErrW-1:0] left_err;
    logic [ColW-1:0]        next_col;
    bit                     first_row;
    dith_word_t             expected_words [$];
    int                     mismatches;

    function new();
      width_reg = WidthReset;
      thr_reg   = ThrReset;
      foreach (row_written[i]) begin
        row_written[i] = 1'b0;
        row_errors[i]  = '0;
      end
      above_left_err = '0;
      left_err       = '0;
      next_col       = '0;
      first_row      = 1'b1;
      mismatches     = 0;
    endfunction

    // width 0 behaves as 1, anything past the line buffer as its size
    function int eff_width();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > MaxWidth) w = MaxWidth;
      return w;
    endfunction

    // a column counter left past the end by a width cut ends the row
    function int clamped_col();
      int c;
      c = next_col;
      if (c > eff_width() - 1) c = eff_width() - 1;
      return c;
    endfunction

    // set when a word without frame_start would read a never-written error entry
    function bit needs_frame_start();
      int c;
      bit last;
      c    = clamped_col();
      last = (c == eff_width() - 1);
      if (first_row) return 1'b0;
      return !row_written[c] || (!last && !row_written[c + 1]);
    endfunction

    function int diffuse(input int v, input logic signed [ErrW-1:0] err, input int weight);
      int sum;
      sum = v + (int'(err) * weight) / 16;
      if (sum < 0) return 0;
      if (sum > int'(PixMax)) return int'(PixMax);
      return sum;
    endfunction

    function void take_pixel(input logic [PixW-1:0] pixel, input logic frame_start);
      int c;
      int v;
      int res;
      bit last;
      logic signed [ErrW-1:0] err;
      dith_word_t word;
      if (frame_start) begin
        next_col  = '0;
        first_row = 1'b1;
      end
      c    = clamped_col();
      last = (c == eff_width() - 1);
      v    = pixel;
      if (!first_row) begin
        if (c > 0) v = diffuse(v, above_left_err, WeightAboveLeft);
        v = diffuse(v, row_errors[c], WeightAbove);
        if (!last) v = diffuse(v, row_errors[c + 1], WeightAboveRight);
      end
      if (c > 0) v = diffuse(v, left_err, WeightLeft);
      if (v > int'(thr_reg)) res = int'(PixMax);
      else res = 0;
      err = ErrW'(v - res);
      if (first_row) above_left_err = '0;
      else above_left_err = row_errors[c];
      row_errors[c]  = err;
      row_written[c] = 1'b1;
      left_err       = err;
      if (last) begin
        next_col  = '0;
        first_row = 1'b0;
      end else begin
        next_col = ColW'(c + 1);
      end
      word.dithered = PixW'(res);
      word.row_end  = last;
      expected_words.insert(expected_words.size(), word);
    endfunction

    function void match_output(input logic [PixW-1:0] dithered, input logic row_end);
      dith_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual dithered=%0d row_end=%0b",
                 $time, dithered, row_end);
        return;
      end
      want = expected_words.pop_front();
      if (dithered !== want.dithered) begin
        mismatches++;
        $display("%0t: dithered expected %0d actual %0d", $time, want.dithered, dithered);
      end
      if (row_end !== want.row_end) begin
        mismatches++;
        $display("%0t: row_end expected %0b actual %0b", $time, want.row_end, row_end);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  fsd_pix_in_if  pix ();
  fsd_pix_out_if dith ();

  dither_checker dither_sb = new();

  // remaining words of a stretch with no idling, one count per side
  int gap_calm   = 0;
  int stall_calm = 0;

  floyd_steinberg_binary_dither dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .dith_o  (dith),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle cycles before the next word: half the time none, with occasional runs of
  // back-to-back words
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(8, 64);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // pixels lean toward the rails and the threshold so clamping and ties show up
  function automatic logic [PixW-1:0] pick_pixel();
    int near;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PixMax;
      2: begin
        near = int'(dither_sb.thr_reg) + int'($urandom_range(0, 4)) - 2;
        if (near < 0) near = 0;
        if (near > int'(PixMax)) near = int'(PixMax);
        return PixW'(near);
      end
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // one input word; returns at the edge that accepts it, valid still high
  task automatic send_word(input logic [PixW-1:0] pixel, input logic frame_start);
    int gap;
    gap = pick_wait(gap_calm);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid       <= 1'b1;
    pix.pixel       <= pixel;
    pix.frame_start <= frame_start;
    do @(posedge clk_i); while (!pix.ready);
    dither_sb.take_pixel(pixel, frame_start);
  endtask

  // stop sending and wait for every owed word; every input yields an output,
  // so an empty queue means the block is idle
  task automatic drain();
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (dither_sb.expected_words.size() != 0);
  endtask

  // leaves psel high so a second transfer can follow straight from access to setup
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_config(input logic [CfgWidthW-1:0] width, input logic [ThrW-1:0] thr);
    drain();
    apb_write(WidthAddr, DataW'(width));
    dither_sb.width_reg = width;
    apb_write(ThrAddr, DataW'(thr));
    dither_sb.thr_reg = thr;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly one long frame with random content; a stray frame_start now and
  // then, and a forced one whenever the width grew past the stored row
  task automatic run_phase(input logic [CfgWidthW-1:0] width, input logic [ThrW-1:0] thr,
                           input int count);
    logic fs;
    set_config(width, thr);
    for (int n = 0; n < count; n++) begin
      if (n == 0) fs = ($urandom_range(0, 1) == 1);
      else fs = ($urandom_range(0, 199) == 0);
      if (dither_sb.needs_frame_start()) fs = 1'b1;
      // now and then hold off until every owed word has come back
      if ($urandom_range(0, 99) == 0) drain();
      send_word(pick_pixel(), fs);
    end
  endtask

  function automatic logic [ThrW-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 8'd255;
      2: return ThrReset;
      default: return ThrW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_directed();
    // three-wide rows: tie at the threshold, then rows that saturate both ways
    set_config(11'd3, 8'd128);
    send_word(8'd0, 1'b1);
    send_word(8'd255, 1'b0);
    send_word(8'd128, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd0, 1'b0);
    // frame restart in mid-row
    send_word(8'd200, 1'b0);
    send_word(8'd50, 1'b1);
    send_word(8'd77, 1'b0);
    // width cut while the column counter is past the new last column
    set_config(11'd5, 8'd200);
    send_word(8'd180, 1'b1);
    send_word(8'd90, 1'b0);
    send_word(8'd240, 1'b0);
    send_word(8'd10, 1'b0);
    set_config(11'd2, 8'd200);
    send_word(8'd255, 1'b0);
    send_word(8'd10, 1'b0);
    send_word(8'd250, 1'b0);
    // single-column rows with the lowest threshold
    set_config(11'd1, 8'd0);
    send_word(8'd0, 1'b1);
    send_word(8'd1, 1'b0);
    send_word(8'd255, 1'b0);
  endtask

  task automatic run_random();
    int sent;
    int pick;
    int w;
    int weff;
    int rows;
    int count;
    sent = 0;
    while (sent < RandomPixels) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) w = $urandom_range(1, 8);
      else if (pick < 80) w = $urandom_range(9, 40);
      else if (pick < 90) w = $urandom_range(41, 160);
      else if (pick < 95) w = 0;
      else w = $urandom_range(1, 3);
      weff  = (w == 0) ? 1 : w;
      rows  = (weff > 40) ? 2 : $urandom_range(2, 5);
      count = weff * rows + $urandom_range(0, weff);
      if (count > RandomPixels - sent) count = RandomPixels - sent;
      run_phase(CfgWidthW'(w), pick_threshold(), count);
      sent += count;
    end
  endtask

  // full line buffer: the top register value, then the exact maximum and one past it
  task automatic run_wide();
    run_phase(11'd2047, pick_threshold(), WidePixels);
    run_phase(11'd1024, pick_threshold(), EdgePixels);
    run_phase(11'd1025, pick_threshold(), EdgePixels);
  endtask

  // output side: random stalls per word, results checked in order
  initial begin
    int stall;
    dith.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = pick_wait(stall_calm);
      if (stall > 0) begin
        dith.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      dith.ready <= 1'b1;
      do @(posedge clk_i); while (!dith.valid);
      dither_sb.match_output(dith.dithered, dith.row_end);
    end
  end

  // main sequence: reset, directed words, random phases, full-width rows
  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix.valid       <= 1'b0;
    pix.pixel       <= '0;
    pix.frame_start <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    run_wide();
    drain();
    // spare edges after draining catch any stray extra word
    repeat (4) @(posedge clk_i);
    if (dither_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // timeout, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
